/* design/ssst_pkg.sv */
// Shared types and fixed widths for the sample set statistics block.
package ssst_pkg;

   localparam int SAMPLE_W    = 32;  // Q15.16 sample, min, max and mean
   localparam int COUNT_OUT_W = 11;  // width of the reported sample count
   localparam int VAR_W       = 64;  // variance quotient fed to the square root
   localparam int ROOT_W      = 32;  // square root result width

   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

/* design/ssst_front.sv */
// Load side: stores samples and keeps running minimum, maximum, sum and count.
module ssst_front #(
   parameter int MAX_SAMPLES = 1024,
   parameter int ADDR_W      = 10,
   parameter int CNT_W       = 11,
   parameter int SUM_W       = 43
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  ssst_pkg::sample_type       req_sample,
   input  logic                       req_last,
   input  logic                       load_ok,
   output logic                       mem_we,
   output logic [ADDR_W-1:0]          mem_addr,
   output ssst_pkg::sample_type       mem_wdata,
   output logic                       job_push,
   output logic [CNT_W-1:0]           job_count,
   output ssst_pkg::sample_type       job_min,
   output ssst_pkg::sample_type       job_max,
   output logic signed [SUM_W-1:0]    job_sum,
   output logic                       job_ovf
);

   logic                    accept;
   logic                    room;
   logic [CNT_W-1:0]        cnt_ff, cnt_in, cnt_nx;
   ssst_pkg::sample_type    min_ff, min_in, min_nx;
   ssst_pkg::sample_type    max_ff, max_in, max_nx;
   logic signed [SUM_W-1:0] sum_ff, sum_in, sum_nx;
   logic                    ovf_ff, ovf_in, ovf_nx;

   assign accept    = req_valid & load_ok;
   assign req_stall = ~load_ok;
   assign room      = cnt_ff < CNT_W'(MAX_SAMPLES);

   assign mem_we    = accept & room;
   assign mem_addr  = cnt_ff[ADDR_W-1:0];
   assign mem_wdata = req_sample;

   always_comb begin
      cnt_nx = cnt_ff;
      min_nx = min_ff;
      max_nx = max_ff;
      sum_nx = sum_ff;
      ovf_nx = ovf_ff;
      if (accept) begin
         if (room) begin
            if (cnt_ff == '0) begin
               min_nx = req_sample;
               max_nx = req_sample;
            end else begin
               if (req_sample < min_ff) min_nx = req_sample;
               if (req_sample > max_ff) max_nx = req_sample;
            end
            sum_nx = sum_ff + SUM_W'(req_sample);
            cnt_nx = cnt_ff + CNT_W'(1);
         end else begin
            ovf_nx = 1'b1;
         end
      end
      job_push  = accept & req_last;
      job_count = cnt_nx;
      job_min   = min_nx;
      job_max   = max_nx;
      job_sum   = sum_nx;
      job_ovf   = ovf_nx;
      // a finished set hands off its totals and the front starts over
      if (job_push) begin
         cnt_in = '0;
         min_in = '0;
         max_in = '0;
         sum_in = '0;
         ovf_in = 1'b0;
      end else begin
         cnt_in = cnt_nx;
         min_in = min_nx;
         max_in = max_nx;
         sum_in = sum_nx;
         ovf_in = ovf_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         min_ff <= '0;
         max_ff <= '0;
         sum_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         min_ff <= min_in;
         max_ff <= max_in;
         sum_ff <= sum_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

/* design/ssst_queue.sv */
// Two-entry job queue between the load side and the compute side.
module ssst_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             empty,
   output logic             full
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             do_push, do_pop;

   assign empty   = fill_ff == 2'd0;
   assign full    = fill_ff == 2'd2;
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

/* design/ssst_back.sv */
// Compute side: sample memory, mean, deviation pass, shared divider, square root.
module ssst_back #(
   parameter int MAX_SAMPLES = 1024,
   parameter int ADDR_W      = 10,
   parameter int CNT_W       = 11,
   parameter int SUM_W       = 43,
   parameter int ACC_W       = 75
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 mem_we,
   input  logic [ADDR_W-1:0]                    mem_addr,
   input  ssst_pkg::sample_type                 mem_wdata,
   input  logic                                 job_valid,
   output logic                                 job_pop,
   input  logic [CNT_W-1:0]                     job_count,
   input  ssst_pkg::sample_type                 job_min,
   input  ssst_pkg::sample_type                 job_max,
   input  logic signed [SUM_W-1:0]              job_sum,
   input  logic                                 job_ovf,
   output logic                                 mem_free,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ssst_pkg::COUNT_OUT_W-1:0]     rsp_sample_count,
   output ssst_pkg::sample_type                 rsp_minimum,
   output ssst_pkg::sample_type                 rsp_maximum,
   output ssst_pkg::sample_type                 rsp_mean,
   output logic [ssst_pkg::ROOT_W-1:0]          rsp_std_deviation,
   output logic                                 rsp_deviation_valid,
   output logic                                 rsp_overflowed
);

   localparam int STEP_W = $clog2(ACC_W + 1);
   localparam int VW     = ssst_pkg::VAR_W;
   localparam int SW     = ssst_pkg::SAMPLE_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MEAN, ST_PASS, ST_VAR, ST_ROOT, ST_OUT
   } state_type;

   logic [SW-1:0]        mem [MAX_SAMPLES];
   logic [SW-1:0]        rdata_ff;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   ssst_pkg::sample_type min_ff, min_in, max_ff, max_in, mean_ff, mean_in;
   logic                 ovf_ff, ovf_in, neg_ff, neg_in;
   logic [ACC_W-1:0]     num_ff, num_in, num_nx;
   logic [CNT_W-1:0]     rem_ff, rem_in, rem_nx;
   logic [CNT_W-1:0]     den_ff, den_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]     iss_ff, iss_in;
   logic                 rd_vld_ff, rd_vld_in, sq_vld_ff, sq_vld_in;
   logic [VW-1:0]        prod_ff, prod_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [VW-1:0]        rrem_ff, rrem_in, rres_ff, rres_in, rbit_ff, rbit_in;
   logic                 out_vld_ff, out_vld_in;
   logic [ssst_pkg::ROOT_W-1:0] std_ff, std_in;
   logic                 dev_vld_ff, dev_vld_in;

   logic [CNT_W:0]       trial;
   logic                 ge;
   logic [SUM_W-1:0]     sum_mag;
   logic [SW-1:0]        quo32;
   logic                 issue;
   logic signed [SW:0]   diff;
   logic [SW-1:0]        mag;
   logic [VW-1:0]        root_try;

   // sample store: one write port from the load side, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      rdata_ff <= mem[iss_ff[ADDR_W-1:0]];
   end

   assign mem_free = (state_ff == ST_IDLE) || (state_ff == ST_OUT);
   assign job_pop  = (state_ff == ST_IDLE) && job_valid;

   always_comb begin
      // one restoring divide step, shared by the mean and the variance
      trial  = {rem_ff, num_ff[ACC_W-1]};
      ge     = trial >= {1'b0, den_ff};
      rem_nx = ge ? CNT_W'(trial - {1'b0, den_ff}) : CNT_W'(trial);
      num_nx = {num_ff[ACC_W-2:0], ge};
      quo32  = num_nx[SW-1:0];

      sum_mag  = job_sum[SUM_W-1] ? SUM_W'(-job_sum) : SUM_W'(job_sum);
      issue    = (state_ff == ST_PASS) && (iss_ff != count_ff);
      diff     = $signed({rdata_ff[SW-1], rdata_ff}) - $signed({mean_ff[SW-1], mean_ff});
      mag      = diff[SW] ? SW'(-diff) : SW'(diff);
      root_try = rres_ff + rbit_ff;

      state_in   = state_ff;
      count_in   = count_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      mean_in    = mean_ff;
      ovf_in     = ovf_ff;
      neg_in     = neg_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      step_in    = step_ff;
      iss_in     = iss_ff;
      rd_vld_in  = issue;
      sq_vld_in  = rd_vld_ff;
      prod_in    = VW'(mag) * VW'(mag);
      acc_in     = sq_vld_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff;
      rrem_in    = rrem_ff;
      rres_in    = rres_ff;
      rbit_in    = rbit_ff;
      out_vld_in = out_vld_ff;
      std_in     = std_ff;
      dev_vld_in = dev_vld_ff;

      if (issue) iss_in = iss_ff + CNT_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               count_in = job_count;
               min_in   = job_min;
               max_in   = job_max;
               ovf_in   = job_ovf;
               neg_in   = job_sum[SUM_W-1];
               num_in   = ACC_W'(sum_mag);
               rem_in   = '0;
               den_in   = job_count;
               step_in  = STEP_W'(ACC_W);
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            num_in  = num_nx;
            rem_in  = rem_nx;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               mean_in = neg_ff ? SW'(-quo32) : quo32;
               if (count_ff >= CNT_W'(2)) begin
                  iss_in   = '0;
                  acc_in   = '0;
                  state_in = ST_PASS;
               end else begin
                  // single sample: no spread to report
                  std_in     = '0;
                  dev_vld_in = 1'b0;
                  out_vld_in = 1'b1;
                  state_in   = ST_OUT;
               end
            end
         end
         ST_PASS: begin
            if (!issue && !rd_vld_ff && !sq_vld_ff) begin
               num_in   = acc_ff;
               rem_in   = '0;
               den_in   = count_ff - CNT_W'(1);
               step_in  = STEP_W'(ACC_W);
               state_in = ST_VAR;
            end
         end
         ST_VAR: begin
            num_in  = num_nx;
            rem_in  = rem_nx;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               if (|num_nx[ACC_W-1:VW]) begin
                  std_in     = '1;
                  dev_vld_in = 1'b1;
                  out_vld_in = 1'b1;
                  state_in   = ST_OUT;
               end else begin
                  rrem_in  = num_nx[VW-1:0];
                  rres_in  = '0;
                  rbit_in  = VW'(1) << (VW - 2);
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            if (rrem_ff >= root_try) begin
               rrem_in = rrem_ff - root_try;
               rres_in = (rres_ff >> 1) + rbit_ff;
            end else begin
               rres_in = rres_ff >> 1;
            end
            rbit_in = rbit_ff >> 2;
            if (rbit_ff == VW'(1)) begin
               std_in     = rres_in[ssst_pkg::ROOT_W-1:0];
               dev_vld_in = 1'b1;
               out_vld_in = 1'b1;
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               out_vld_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
         sq_vld_ff  <= 1'b0;
         iss_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         rd_vld_ff  <= rd_vld_in;
         sq_vld_ff  <= sq_vld_in;
         iss_ff     <= iss_in;
      end
      count_ff   <= count_in;
      min_ff     <= min_in;
      max_ff     <= max_in;
      mean_ff    <= mean_in;
      ovf_ff     <= ovf_in;
      neg_ff     <= neg_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      step_ff    <= step_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      rrem_ff    <= rrem_in;
      rres_ff    <= rres_in;
      rbit_ff    <= rbit_in;
      std_ff     <= std_in;
      dev_vld_ff <= dev_vld_in;
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_sample_count    = ssst_pkg::COUNT_OUT_W'(count_ff);
   assign rsp_minimum         = min_ff;
   assign rsp_maximum         = max_ff;
   assign rsp_mean            = mean_ff;
   assign rsp_std_deviation   = std_ff;
   assign rsp_deviation_valid = dev_vld_ff;
   assign rsp_overflowed      = ovf_ff;

   a_valid_only_out: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> state_ff == ST_OUT)
      else $error("result valid outside output state");

   a_dev_needs_two: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && dev_vld_ff) |-> count_ff >= CNT_W'(2))
      else $error("deviation marked valid with fewer than two samples");

   a_no_write_in_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PASS) |-> !mem_we)
      else $error("sample store written during deviation pass");

endmodule

/* design/sample_set_statistics.sv */
// Top level of the sample set statistics block: load side, job queue, compute side.
//
// Samples (signed Q15.16) are taken one per cycle on the req_ channel while
// req_stall is low; the item with req_last set closes the set. Up to MAX_SAMPLES
// samples are stored, later ones are dropped and flagged in rsp_overflowed. One
// rsp_ item per set carries count, minimum, maximum, mean (truncated toward zero)
// and the sample standard deviation (unsigned Q16.16, flagged invalid and zero for
// a single sample). Loading runs at one item per cycle while req_stall is low.
// After the last item the compute side runs two serial divisions (mean, variance),
// a second pass through the sample memory's read port, and the square root.
// req_stall goes high in the cycle after the last item of a set and stays high
// through the whole compute run, until the result is presented; a new set may
// load while the previous result waits on rsp_stall.
module sample_set_statistics #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [31:0]                req_sample,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [10:0]                       rsp_sample_count,
   output logic signed [31:0]                rsp_minimum,
   output logic signed [31:0]                rsp_maximum,
   output logic signed [31:0]                rsp_mean,
   output logic [31:0]                       rsp_std_deviation,
   output logic                              rsp_deviation_valid,
   output logic                              rsp_overflowed
);

   localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SW     = ssst_pkg::SAMPLE_W;
   localparam int SUM_W  = SW + CNT_W;
   localparam int ACC_W  = ssst_pkg::VAR_W + CNT_W;
   localparam int JOB_W  = CNT_W + SW + SW + SUM_W + 1;

   logic                    load_ok;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_addr;
   ssst_pkg::sample_type    mem_wdata;
   logic                    job_push, job_pop, q_empty, q_full, mem_free;
   logic [CNT_W-1:0]        f_count;
   ssst_pkg::sample_type    f_min, f_max;
   logic signed [SUM_W-1:0] f_sum;
   logic                    f_ovf;
   logic [JOB_W-1:0]        q_head;

   // new samples may only go in once the store is not being read back
   assign load_ok = q_empty & mem_free;

   ssst_front #(
      .MAX_SAMPLES(MAX_SAMPLES), .ADDR_W(ADDR_W), .CNT_W(CNT_W), .SUM_W(SUM_W)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_sample(req_sample), .req_last(req_last),
      .load_ok(load_ok),
      .mem_we(mem_we), .mem_addr(mem_addr), .mem_wdata(mem_wdata),
      .job_push(job_push), .job_count(f_count), .job_min(f_min),
      .job_max(f_max), .job_sum(f_sum), .job_ovf(f_ovf)
   );

   ssst_queue #(.WIDTH(JOB_W)) u_queue (
      .clock(clock), .reset(reset),
      .push(job_push), .push_data({f_count, f_min, f_max, f_sum, f_ovf}),
      .pop(job_pop), .head(q_head), .empty(q_empty), .full(q_full)
   );

   ssst_back #(
      .MAX_SAMPLES(MAX_SAMPLES), .ADDR_W(ADDR_W), .CNT_W(CNT_W),
      .SUM_W(SUM_W), .ACC_W(ACC_W)
   ) u_back (
      .clock(clock), .reset(reset),
      .mem_we(mem_we), .mem_addr(mem_addr), .mem_wdata(mem_wdata),
      .job_valid(~q_empty), .job_pop(job_pop),
      .job_count(q_head[JOB_W-1 -: CNT_W]),
      .job_min($signed(q_head[SW+SW+SUM_W -: SW])),
      .job_max($signed(q_head[SW+SUM_W -: SW])),
      .job_sum($signed(q_head[SUM_W -: SUM_W])),
      .job_ovf(q_head[0]),
      .mem_free(mem_free),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sample_count(rsp_sample_count), .rsp_minimum(rsp_minimum),
      .rsp_maximum(rsp_maximum), .rsp_mean(rsp_mean),
      .rsp_std_deviation(rsp_std_deviation),
      .rsp_deviation_valid(rsp_deviation_valid),
      .rsp_overflowed(rsp_overflowed)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_full)
      else $error("set closed while job queue full");

endmodule

/* verif/sample_set_statistics_tb.sv */
// Testbench for sample_set_statistics: random and directed sample sets, checked against a model.
module sample_set_statistics_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 1024;
   localparam longint CYCLE_LIMIT = 2000000;

   // Idling phases: percent idle on sender and receiver
   typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_type;

   typedef struct {
      ssst_pkg::sample_type value;
      logic                 last;
   } sample_item_type;

   typedef struct {
      logic [10:0]          count;
      ssst_pkg::sample_type min_val;
      ssst_pkg::sample_type max_val;
      ssst_pkg::sample_type mean_val;
      logic [31:0]          std_dev;
      logic                 dev_ok;
      logic                 ovf;
   } stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ssst_pkg::sample_type req_sample = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [10:0] rsp_sample_count;
   ssst_pkg::sample_type rsp_minimum, rsp_maximum, rsp_mean;
   logic [31:0] rsp_std_deviation;
   logic rsp_deviation_valid, rsp_overflowed;

   sample_item_type pending_samples[$];
   stats_type       expected_stats[$];
   phase_type       phase = PH_FREE;
   bit              failed = 1'b0;
   bit              req_taken = 1'b0;
   longint          cycle_count = 0;

   // Predictor state
   ssst_pkg::sample_type model_store[CAPACITY];
   int           model_count = 0;
   longint       model_min = 0, model_max = 0, model_sum = 0;
   bit           model_ovf = 1'b0;

   sample_set_statistics uut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] rem, res, b;
      rem = x; res = 0; b = 64'd1 << 62;
      while (b != 0) begin
         if (rem >= res + b) begin
            rem = rem - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Feed one sample into the model; a last sample queues the expected stats.
   task automatic predict_sample(sample_item_type it);
      stats_type s;
      longint mean_l, d;
      logic [127:0] sq_sum, quot;
      logic [63:0] a, root;
      if (model_count < CAPACITY) begin
         model_store[model_count] = it.value;
         if (model_count == 0) begin
            model_min = it.value;
            model_max = it.value;
         end else begin
            if (it.value < model_min) model_min = it.value;
            if (it.value > model_max) model_max = it.value;
         end
         model_sum += it.value;
         model_count++;
      end else begin
         model_ovf = 1'b1;
      end
      if (!it.last) return;
      mean_l = (model_count != 0) ? model_sum / model_count : 0;
      s.count = model_count[10:0];
      s.min_val = model_min[31:0];
      s.max_val = model_max[31:0];
      s.mean_val = mean_l[31:0];
      s.dev_ok = (model_count >= 2);
      s.ovf = model_ovf;
      s.std_dev = '0;
      if (s.dev_ok) begin
         sq_sum = '0;
         for (int i = 0; i < model_count; i++) begin
            d = longint'(model_store[i]) - mean_l;
            a = (d < 0) ? 64'(-d) : 64'(d);
            sq_sum += 128'(a) * 128'(a);
         end
         quot = sq_sum / 128'(model_count - 1);
         if (quot[127:64] != 0) begin
            s.std_dev = '1;
         end else begin
            root = floor_sqrt(quot[63:0]);
            s.std_dev = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
         end
      end
      expected_stats = {expected_stats, s};
      model_count = 0; model_min = 0; model_max = 0; model_sum = 0; model_ovf = 1'b0;
   endtask

   function automatic int idle_pct(bit sender);
      case (phase)
         PH_SEND_IDLE:  return sender ? 45 : 0;
         PH_RECV_STALL: return sender ? 0 : 45;
         PH_BOTH:       return 14;
         default:       return 0;
      endcase
   endfunction

   // Input handshake seen at the accepting edge; the model is fed there.
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) predict_sample(pending_samples.pop_front());
   end

   // Driver: presents the head of the queue, holds it until taken.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // stalled item held steady
         end else if (pending_samples.size() != 0 &&
                      $urandom_range(99) >= idle_pct(1'b1)) begin
            req_valid <= 1'b1;
            req_sample <= pending_samples[0].value;
            req_last <= pending_samples[0].last;
         end else begin
            req_valid <= 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < idle_pct(1'b0));
      end
   end

   // Monitor: compare accepted results with the oldest expectation.
   always @(posedge clock) begin
      stats_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_stats.size() == 0) begin
            $display("%0t: unexpected result count=%0d", $time, rsp_sample_count);
            failed = 1'b1;
         end else begin
            e = expected_stats.pop_front();
            if (rsp_sample_count !== e.count) begin
               $display("%0t: count exp %0d got %0d", $time, e.count, rsp_sample_count);
               failed = 1'b1;
            end
            if (rsp_minimum !== e.min_val) begin
               $display("%0t: minimum exp %0d got %0d", $time, e.min_val, rsp_minimum);
               failed = 1'b1;
            end
            if (rsp_maximum !== e.max_val) begin
               $display("%0t: maximum exp %0d got %0d", $time, e.max_val, rsp_maximum);
               failed = 1'b1;
            end
            if (rsp_mean !== e.mean_val) begin
               $display("%0t: mean exp %0d got %0d", $time, e.mean_val, rsp_mean);
               failed = 1'b1;
            end
            if (rsp_std_deviation !== e.std_dev) begin
               $display("%0t: std_deviation exp %h got %h", $time, e.std_dev,
                        rsp_std_deviation);
               failed = 1'b1;
            end
            if (rsp_deviation_valid !== e.dev_ok) begin
               $display("%0t: deviation_valid exp %b got %b", $time, e.dev_ok,
                        rsp_deviation_valid);
               failed = 1'b1;
            end
            if (rsp_overflowed !== e.ovf) begin
               $display("%0t: overflowed exp %b got %b", $time, e.ovf, rsp_overflowed);
               failed = 1'b1;
            end
         end
      end
   end

   function automatic ssst_pkg::sample_type rand_sample();
      case ($urandom_range(5))
         0:       return ssst_pkg::sample_type'($urandom());
         1:       return ssst_pkg::sample_type'($urandom_range(3) == 0 ?
                                                32'h7FFF_FFFF : 32'h8000_0000);
         2:       return ssst_pkg::sample_type'($signed($urandom_range(2000)) - 1000);
         default: return ssst_pkg::sample_type'($signed($urandom_range(32'h0040_0000))
                                                - 32'sh20_0000);
      endcase
   endfunction

   task automatic queue_set(int n, bit extreme);
      sample_item_type it;
      for (int i = 0; i < n; i++) begin
         it.value = extreme ? ((i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000) : rand_sample();
         it.last = (i == n - 1);
         pending_samples = {pending_samples, it};
      end
   endtask

   initial begin
      int total;
      sample_item_type it;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: single samples (extremes, zero), two- and five-sample extremes, constant set, mixed two-sample set
      it.value = 32'sh8000_0000; it.last = 1'b1; pending_samples = {pending_samples, it};
      it.value = 32'sh7FFF_FFFF; it.last = 1'b1; pending_samples = {pending_samples, it};
      it.value = 32'sh0; it.last = 1'b1; pending_samples = {pending_samples, it};
      queue_set(2, 1'b1);
      queue_set(5, 1'b1);
      for (int i = 0; i < 4; i++) begin
         it.value = -32'sd7; it.last = (i == 3); pending_samples = {pending_samples, it};
      end
      it.value = 32'sh0001_0000; it.last = 1'b0; pending_samples = {pending_samples, it};
      it.value = -32'sh0000_0001; it.last = 1'b1; pending_samples = {pending_samples, it};

      total = 0;
      for (int ph = 0; ph < 4; ph++) begin
         while (pending_samples.size() != 0 || expected_stats.size() != 0)
            @(posedge clock);
         phase = phase_type'(ph);
         while (total < (ph + 1) * 158) begin
            int n;
            n = ($urandom_range(9) == 0) ? $urandom_range(60, 2) : $urandom_range(8, 1);
            queue_set(n, 1'b0);
            total += n;
         end
      end

      while (pending_samples.size() != 0 || expected_stats.size() != 0 || req_valid)
         @(posedge clock);
      repeat (1500) @(posedge clock);
      if (!failed && expected_stats.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

/* files.f */
design/ssst_pkg.sv
design/ssst_front.sv
design/ssst_queue.sv
design/ssst_back.sv
design/sample_set_statistics.sv
verif/sample_set_statistics_tb.sv
